### hdl/obst_pkg.sv
// Shared types and constants for the optimal search tree cost unit.
`timescale 1ns / 1ps

package obst_pkg;

    // Fixed payload widths of the channels
    localparam int FREQ_W       = 16;
    localparam int TOTAL_COST_W = 26;
    localparam int ROOT_INDEX_W = 5;
    localparam int KEY_COUNT_W  = 6;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SPAN,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    // One split candidate handed from the sequencer to the compare unit
    typedef struct packed {
        logic valid;
        logic first;
        logic left_empty;
        logic right_empty;
    } t_split_req;

endpackage

### hdl/obst_in_if.sv
// Input channel: key frequency and last-key flag.
`timescale 1ns / 1ps

interface obst_in_if;
    logic                        valid;
    logic                        ready;
    logic [obst_pkg::FREQ_W-1:0] freq;
    logic                        last;

    modport source (output valid, output freq, output last, input ready);
    modport sink   (input valid, input freq, input last, output ready);
endinterface

// Output channel: optimal cost, root and key count.
interface obst_out_if;
    logic                              valid;
    logic                              ready;
    logic [obst_pkg::TOTAL_COST_W-1:0] total_cost;
    logic [obst_pkg::ROOT_INDEX_W-1:0] root_index;
    logic [obst_pkg::KEY_COUNT_W-1:0]  key_count;

    modport source (output valid, output total_cost, output root_index, output key_count,
                    input ready);
    modport sink   (input valid, input total_cost, input root_index, input key_count,
                    output ready);
endinterface

### hdl/obst_ram.sv
// Single-write, dual-read memory with registered read data.
`timescale 1ns / 1ps

module obst_ram #(
    parameter int   DATA_W = 32,
    parameter int   DEPTH  = 32,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### hdl/obst_split_alu.sv
// Shared add-and-compare unit that tracks the cheapest split of a span.
`timescale 1ns / 1ps

module obst_split_alu #(
    parameter int KEY_W  = 5,
    parameter int COST_W = 28
) (
    input  logic                 i_clk,
    input  logic                 i_init,
    input  obst_pkg::t_split_req i_req,
    input  logic [KEY_W-1:0]     i_root,
    input  logic [COST_W-1:0]    i_left,
    input  logic [COST_W-1:0]    i_right,
    output logic [COST_W-1:0]    o_best,
    output logic [KEY_W-1:0]     o_root
);

    logic [COST_W-1:0] w_left;
    logic [COST_W-1:0] w_right;
    logic [COST_W-1:0] w_sum;
    logic              w_take;

    // Empty subtrees cost nothing
    assign w_left  = i_req.left_empty  ? '0 : i_left;
    assign w_right = i_req.right_empty ? '0 : i_right;
    assign w_sum   = w_left + w_right;

    // Strict compare keeps the lowest root on ties
    assign w_take = i_req.valid && (i_req.first || (w_sum < o_best));

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            o_best <= '0;
            o_root <= '0;
        end else if (w_take) begin
            o_best <= w_sum;
            o_root <= i_root;
        end
    end

endmodule

### hdl/optimal_bst_cost_and_root_unit.sv
// Top level: key loading, diagonal fill sequencer and result register.
//
// Keys are loaded one per cycle while the input is ready, in sorted order; the key
// with last set (or the key that fills MAX_KEYS) closes the set. The unit then fills
// the span cost table diagonal by diagonal with one shared add/compare unit, trying
// one root per cycle out of a dual-read cost table memory. Each span steps through
// its roots, then through a drain state and a write state. The input is not ready
// during the fill; a finished result waits in an output register while the next set
// loads, and the next fill stalls only at its final write if that result has still
// not been taken.
`timescale 1ns / 1ps

module optimal_bst_cost_and_root_unit #(
    parameter int MAX_KEYS  = 32,
    parameter int FREQ_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obst_in_if.sink     i_in,
    obst_out_if.source  o_out
);

    localparam int KW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW   = $clog2(MAX_KEYS + 1);
    localparam int FW   = (FREQ_BITS < obst_pkg::FREQ_W) ? FREQ_BITS : obst_pkg::FREQ_W;
    localparam int SW   = FW + CW;
    localparam int CCW  = FW + 2 * CW;
    localparam int TD   = MAX_KEYS * MAX_KEYS;
    localparam int AW   = (TD > 1) ? $clog2(TD) : 1;

    // Table address of span row..col
    function automatic logic [AW-1:0] f_addr(input logic [KW-1:0] row,
                                             input logic [KW-1:0] col);
        logic [AW-1:0] v_base;
        v_base = AW'(row) * AW'(MAX_KEYS);
        return v_base + AW'(col);
    endfunction

    obst_pkg::t_state r_state, n_state;

    logic [CW-1:0]  r_n;
    logic [SW-1:0]  r_sum;
    logic [KW-1:0]  r_i, r_d, r_r, r_rd_r;
    logic [SW-1:0]  r_weight;
    obst_pkg::t_split_req r_req;

    logic                              r_out_valid;
    logic [obst_pkg::TOTAL_COST_W-1:0] r_out_total;
    logic [obst_pkg::ROOT_INDEX_W-1:0] r_out_root;
    logic [obst_pkg::KEY_COUNT_W-1:0]  r_out_count;

    logic           w_in_ready, w_issue, w_drain, w_write;
    logic           w_acc, w_close, w_single;
    logic [KW-1:0]  w_j, w_nk;
    logic [SW-1:0]  w_f, w_new_sum;
    logic           w_last_span, w_out_free, w_advance;
    logic           w_left_empty, w_right_empty;
    logic [CCW-1:0] w_best, w_span_cost;
    logic [KW-1:0]  w_best_root;
    logic           w_alu_init;

    logic           w_cost_we;
    logic [AW-1:0]  w_cost_waddr, w_cost_ra, w_cost_rb;
    logic [CCW-1:0] w_cost_wdata, w_cost_da, w_cost_db;
    logic [KW-1:0]  w_pre_rb;
    logic [SW-1:0]  w_pre_hi, w_pre_lo;

    // Datapath helpers
    assign w_j         = r_i + r_d;
    assign w_nk        = r_n[KW-1:0];
    assign w_f         = SW'(i_in.freq[FW-1:0]);
    assign w_new_sum   = (r_n == '0) ? w_f : r_sum + w_f;
    assign w_acc       = i_in.valid && w_in_ready;
    assign w_close     = i_in.last || ((r_n + CW'(1)) == CW'(MAX_KEYS));
    assign w_single    = (r_n == '0);
    assign w_last_span = (r_i == '0) && (CW'(w_j) == (r_n - CW'(1)));
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_advance   = !w_last_span || w_out_free;
    assign w_span_cost = w_best + CCW'(r_weight);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            obst_pkg::ST_LOAD: begin
                if (w_acc && w_close) begin
                    n_state = w_single ? obst_pkg::ST_WRITE : obst_pkg::ST_SPAN;
                end
            end
            obst_pkg::ST_SPAN: begin
                if (r_r == w_j) begin
                    n_state = obst_pkg::ST_DRAIN;
                end
            end
            obst_pkg::ST_DRAIN: begin
                n_state = obst_pkg::ST_WRITE;
            end
            obst_pkg::ST_WRITE: begin
                if (w_advance) begin
                    n_state = w_last_span ? obst_pkg::ST_LOAD : obst_pkg::ST_SPAN;
                end
            end
            default: n_state = obst_pkg::ST_LOAD;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_drain    = 1'b0;
        w_write    = 1'b0;
        unique case (r_state)
            obst_pkg::ST_LOAD:  w_in_ready = 1'b1;
            obst_pkg::ST_SPAN:  w_issue    = 1'b1;
            obst_pkg::ST_DRAIN: w_drain    = 1'b1;
            obst_pkg::ST_WRITE: w_write    = 1'b1;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obst_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Load keys, step through spans and roots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (w_acc) begin
            r_n <= r_n + CW'(1);
        end else if (w_write && w_advance && w_last_span) begin
            r_n <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sum <= w_new_sum;
        end
        if (w_acc && w_close) begin
            r_i <= '0;
            r_r <= '0;
            r_d <= w_single ? KW'(0) : KW'(1);
        end else if (w_issue) begin
            r_r <= r_r + KW'(1);
        end else if (w_write && w_advance && !w_last_span) begin
            if ((CW'(w_j) + CW'(1)) < r_n) begin
                r_i <= r_i + KW'(1);
                r_r <= r_i + KW'(1);
            end else begin
                r_i <= '0;
                r_r <= '0;
                r_d <= r_d + KW'(1);
            end
        end
        if (w_acc) begin
            r_weight <= w_f;
        end else if (w_drain) begin
            r_weight <= w_pre_hi - ((r_i == '0) ? SW'(0) : w_pre_lo);
        end
    end

    // Split candidate pipeline, aligned with the table read data
    assign w_left_empty  = (r_r == r_i);
    assign w_right_empty = (r_r == w_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req.valid <= w_issue;
        end
        r_req.first       <= w_left_empty;
        r_req.left_empty  <= w_left_empty;
        r_req.right_empty <= w_right_empty;
        r_rd_r            <= r_r;
    end

    // Cost table ports
    assign w_cost_ra    = f_addr(r_i, w_left_empty ? r_r : r_r - KW'(1));
    assign w_cost_rb    = f_addr(w_right_empty ? r_r : r_r + KW'(1), w_j);
    assign w_cost_we    = w_acc || (w_write && w_advance);
    assign w_cost_waddr = w_acc ? f_addr(w_nk, w_nk) : f_addr(r_i, w_j);
    assign w_cost_wdata = w_acc ? CCW'(w_f) : w_span_cost;

    obst_ram #(
        .DATA_W (CCW),
        .DEPTH  (TD)
    ) u_cost_ram (
        .i_clk     (i_clk),
        .i_we      (w_cost_we),
        .i_waddr   (w_cost_waddr),
        .i_wdata   (w_cost_wdata),
        .i_raddr_a (w_cost_ra),
        .i_raddr_b (w_cost_rb),
        .o_rdata_a (w_cost_da),
        .o_rdata_b (w_cost_db)
    );

    // Prefix sums for span weights
    assign w_pre_rb = (r_i == '0) ? r_i : r_i - KW'(1);

    obst_ram #(
        .DATA_W (SW),
        .DEPTH  (MAX_KEYS)
    ) u_prefix_ram (
        .i_clk     (i_clk),
        .i_we      (w_acc),
        .i_waddr   (w_nk),
        .i_wdata   (w_new_sum),
        .i_raddr_a (w_j),
        .i_raddr_b (w_pre_rb),
        .o_rdata_a (w_pre_hi),
        .o_rdata_b (w_pre_lo)
    );

    // Shared add/compare unit
    assign w_alu_init = w_acc && w_close && w_single;

    obst_split_alu #(
        .KEY_W  (KW),
        .COST_W (CCW)
    ) u_split_alu (
        .i_clk   (i_clk),
        .i_init  (w_alu_init),
        .i_req   (r_req),
        .i_root  (r_rd_r),
        .i_left  (w_cost_da),
        .i_right (w_cost_db),
        .o_best  (w_best),
        .o_root  (w_best_root)
    );

    // Hold the result until the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_write && w_last_span && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write && w_last_span && w_out_free) begin
            r_out_total <= obst_pkg::TOTAL_COST_W'(w_span_cost);
            r_out_root  <= obst_pkg::ROOT_INDEX_W'(w_best_root);
            r_out_count <= obst_pkg::KEY_COUNT_W'(r_n);
        end
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.total_cost = r_out_total;
    assign o_out.root_index = r_out_root;
    assign o_out.key_count  = r_out_count;

endmodule

### hdl/obst_checker.sv
// Port-level checks for the optimal search tree unit, bound to the top level.
`timescale 1ns / 1ps

module obst_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [obst_pkg::TOTAL_COST_W-1:0] i_total_cost,
    input logic [obst_pkg::ROOT_INDEX_W-1:0] i_root_index,
    input logic [obst_pkg::KEY_COUNT_W-1:0]  i_key_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_total_cost) && $stable(i_root_index) && $stable(i_key_count)))
        else $error("result changed while stalled");

    // A new result only comes out of a fill, when input was closed
    a_out_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a fill");

    // A single key is its own root
    a_single_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_key_count == obst_pkg::KEY_COUNT_W'(1))) |-> (i_root_index == '0))
        else $error("single key with nonzero root");

endmodule

bind optimal_bst_cost_and_root_unit obst_checker u_obst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_total_cost (o_out.total_cost),
    .i_root_index (o_out.root_index),
    .i_key_count  (o_out.key_count)
);

### dv/obst_result_checker.sv
// Checker for the optimal search tree unit: predicts each key set's cost, root and key count, then compares.
`timescale 1ns / 1ps

module obst_result_checker #(
    parameter int MAX_KEYS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    obst_in_if   i_in,
    obst_out_if  i_out,
    output int   o_error_count,
    output int   o_pending_count
);

    typedef struct packed {
        logic [obst_pkg::TOTAL_COST_W-1:0] total_cost;
        logic [obst_pkg::ROOT_INDEX_W-1:0] root_index;
        logic [obst_pkg::KEY_COUNT_W-1:0]  key_count;
    } t_tree_result;

    t_tree_result                expected_trees [$];
    logic [obst_pkg::FREQ_W-1:0] set_freq [MAX_KEYS];
    int                          set_size      = 0;
    int                          error_count   = 0;
    int                          pending_count = 0;

    assign o_error_count   = error_count;
    assign o_pending_count = pending_count;

    // Fill the span table diagonal by diagonal over the loaded keys
    function automatic t_tree_result solve_optimal_tree(input int n);
        longint unsigned span_cost [MAX_KEYS][MAX_KEYS];
        int              span_root [MAX_KEYS][MAX_KEYS];
        longint unsigned run_sum [MAX_KEYS];
        longint unsigned best;
        longint unsigned cand;
        longint unsigned weight;
        int              j;
        t_tree_result    res;
        for (int i = 0; i < n; i++) begin
            run_sum[i]      = ((i == 0) ? 64'd0 : run_sum[i-1]) + set_freq[i];
            span_cost[i][i] = set_freq[i];
            span_root[i][i] = i;
        end
        for (int d = 1; d < n; d++) begin
            for (int i = 0; i + d < n; i++) begin
                j    = i + d;
                best = 0;
                span_root[i][j] = i;
                // Keep the lowest root on ties: replace only on a strictly smaller cost
                for (int r = i; r <= j; r++) begin
                    cand = ((r > i) ? span_cost[i][r-1] : 64'd0)
                         + ((r < j) ? span_cost[r+1][j] : 64'd0);
                    if (r == i || cand < best) begin
                        best            = cand;
                        span_root[i][j] = r;
                    end
                end
                weight          = run_sum[j] - ((i == 0) ? 64'd0 : run_sum[i-1]);
                span_cost[i][j] = best + weight;
            end
        end
        res.total_cost = obst_pkg::TOTAL_COST_W'(span_cost[0][n-1]);
        res.root_index = obst_pkg::ROOT_INDEX_W'(span_root[0][n-1]);
        res.key_count  = obst_pkg::KEY_COUNT_W'(n);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] tree result: %s", $time, msg);
    endtask

    // Track key transactions, queue predictions, compare result transactions
    always @(posedge i_clk) begin
        t_tree_result got;
        t_tree_result want;
        if (!i_rst_n) begin
            set_size = 0;
            expected_trees.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                set_freq[set_size] = i_in.freq;
                set_size++;
                // A full set closes itself even without the last flag
                if (i_in.last || set_size == MAX_KEYS) begin
                    expected_trees.insert(expected_trees.size(),
                                          solve_optimal_tree(set_size));
                    set_size = 0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                got.total_cost = i_out.total_cost;
                got.root_index = i_out.root_index;
                got.key_count  = i_out.key_count;
                if (expected_trees.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction cost %0d root %0d keys %0d",
                                              got.total_cost, got.root_index, got.key_count));
                end else begin
                    want = expected_trees.pop_front();
                    if (got.total_cost !== want.total_cost)
                        report_mismatch($sformatf("total_cost got %0d expected %0d",
                                                  got.total_cost, want.total_cost));
                    if (got.root_index !== want.root_index)
                        report_mismatch($sformatf("root_index got %0d expected %0d",
                                                  got.root_index, want.root_index));
                    if (got.key_count !== want.key_count)
                        report_mismatch($sformatf("key_count got %0d expected %0d",
                                                  got.key_count, want.key_count));
                end
            end
        end
        pending_count = expected_trees.size();
    end

endmodule

### dv/tb.sv
// Testbench top for the optimal search tree unit: key stimulus, result sink, watchdog, verdict.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_KEYS     = 32;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_LIMIT  = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic gaps_on;
    int   error_count;
    int   pending_count;
    int   quiet_cycles = 0;
    int   random_items;
    int   kind;
    int   set_len;
    logic set_last;

    obst_in_if  key_if ();
    obst_out_if tree_if ();

    optimal_bst_cost_and_root_unit #(
        .MAX_KEYS  (MAX_KEYS),
        .FREQ_BITS (obst_pkg::FREQ_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .o_out   (tree_if)
    );

    obst_result_checker #(
        .MAX_KEYS (MAX_KEYS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (key_if),
        .i_out           (tree_if),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    always #4 i_clk = ~i_clk;

    // Stall the result side at random while gaps are enabled
    always @(negedge i_clk) begin
        tree_if.ready = gaps_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (key_if.valid && key_if.ready) || (tree_if.valid && tree_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("optimal_bst_cost_and_root_unit verification failed");
            $finish;
        end
    end

    // Mix extremes, small values that force ties, and full-range values
    function automatic logic [obst_pkg::FREQ_W-1:0] pick_freq();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        if (roll < 45) return obst_pkg::FREQ_W'($urandom_range(0, 15));
        return obst_pkg::FREQ_W'($urandom);
    endfunction

    // Offer one key, with a random gap first, and hold it until accepted
    task automatic send_key(input logic [obst_pkg::FREQ_W-1:0] freq, input logic mark_last);
        while (gaps_on && $urandom_range(0, 99) < 29) begin
            key_if.valid = 1'b0;
            @(negedge i_clk);
        end
        key_if.valid = 1'b1;
        key_if.freq  = freq;
        key_if.last  = mark_last;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_set(input int n, input logic mark_last);
        for (int k = 0; k < n; k++)
            send_key(pick_freq(), (k == n - 1) ? mark_last : 1'b0);
    endtask

    initial begin
        key_if.valid  = 1'b0;
        key_if.freq   = '0;
        key_if.last   = 1'b0;
        gaps_on       = 1'b1;
        i_rst_n       = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single keys at both extremes
        send_key('0, 1'b1);
        send_key('1, 1'b1);
        // Equal weights: ties resolve to the lowest root
        send_key(16'd1, 1'b0);
        send_key(16'd1, 1'b1);
        for (int k = 0; k < 3; k++) send_key('0, k == 2);
        for (int k = 0; k < 3; k++) send_key('1, k == 2);
        // Alternating bit patterns
        send_key(16'hAAAA, 1'b0);
        send_key(16'h5555, 1'b0);
        send_key(16'h0001, 1'b0);
        send_key(16'h8000, 1'b1);
        // Skewed pairs, heavy key on either side
        send_key(16'd1, 1'b0);
        send_key('1, 1'b1);
        send_key('1, 1'b0);
        send_key(16'd1, 1'b1);
        send_key(16'd5, 1'b0);
        send_key(16'd1, 1'b0);
        send_key(16'd9, 1'b0);
        send_key(16'd3, 1'b0);
        send_key(16'd7, 1'b1);

        // Random sets, mostly small, a few full, some full ones without the last flag
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            gaps_on  = !(random_items >= 300 && random_items < 480);
            kind     = $urandom_range(0, 99);
            set_last = 1'b1;
            if (kind < 70) begin
                set_len = $urandom_range(1, 8);
            end else if (kind < 85) begin
                set_len = $urandom_range(9, 16);
            end else if (kind < 92) begin
                set_len = $urandom_range(17, MAX_KEYS - 1);
            end else begin
                set_len  = MAX_KEYS;
                set_last = (kind < 96);
            end
            send_set(set_len, set_last);
            random_items += set_len;
        end
        key_if.valid = 1'b0;
        gaps_on      = 1'b1;

        // Drain outstanding results, then let the unit settle
        while (pending_count != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("optimal_bst_cost_and_root_unit verification clean");
        else
            $display("optimal_bst_cost_and_root_unit verification failed");
        $finish;
    end

endmodule
